### rtl/sgck_pkg.sv
// shared widths, register codes, reset values and helpers for the grid cell key unit
package sgck_pkg;

    localparam int POS_W      = 16;
    localparam int COORD_BITS = 16;
    localparam int LEN_W      = 16;
    localparam int KEY_W      = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W      = POS_W;
    localparam int HIL_LEVELS = POS_W - 1;
    localparam int S_W        = POS_W - 1;
    localparam int SQ_W       = 2 * S_W;
    localparam int PIPE_D     = DIV_W + 1 + HIL_LEVELS;

    localparam logic [LEN_W-1:0]  SCREEN_LENGTH_RST = LEN_W'(5000);
    localparam logic [LEN_W-1:0]  CELL_SIZE_RST     = LEN_W'(100);

    typedef enum logic [MODE_W-1:0] {
        CURVE_LINEAR  = 2'd0,
        CURVE_MORTON  = 2'd1,
        CURVE_HILBERT = 2'd2
    } t_curve;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_LENGTH = 2'd0,
        REG_CELL_SIZE     = 2'd1,
        REG_CURVE_MODE    = 2'd2
    } t_cfg_reg;

    function automatic logic [2*COORD_BITS-1:0] spread_bits(input logic [COORD_BITS-1:0] v);
        logic [2*COORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

endpackage

### rtl/sgck_if.sv
// channel interfaces: point positions in, cell keys out, register writes

interface sgck_pos_if;
    logic                          valid;
    logic                          ready;
    logic [sgck_pkg::POS_W-1:0]    pos_x;
    logic [sgck_pkg::POS_W-1:0]    pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface sgck_key_if;
    logic                          valid;
    logic                          ready;
    logic [sgck_pkg::KEY_W-1:0]    cell_key;

    modport source (output valid, output cell_key, input ready);
    modport sink   (input valid, input cell_key, output ready);
endinterface

interface sgck_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sgck_pkg::CFG_IDX_W-1:0]   index;
    logic [sgck_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sgck_div.sv
// pipelined restoring divider, one quotient bit per stage
module sgck_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sgck_pkg::DIV_W-1:0]  i_dividend,
    input  logic [sgck_pkg::DIV_W-1:0]  i_divisor,
    output logic [sgck_pkg::DIV_W-1:0]  o_quotient
);

    localparam int W = sgck_pkg::DIV_W;

    logic [W-1:0] r_rem [W-1];
    logic [W-1:0] r_dvd [W-1];
    logic [W-1:0] r_dvs [W-1];
    logic [W-1:0] r_quo [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] src_rem;
        logic [W-1:0] src_dvd;
        logic [W-1:0] src_dvs;
        logic [W-1:0] src_quo;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         take;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_dvd = i_dividend;
            assign src_dvs = i_divisor;
            assign src_quo = '0;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_dvd = r_dvd[k-1];
            assign src_dvs = r_dvs[k-1];
            assign src_quo = r_quo[k-1];
        end

        assign trial = {src_rem, src_dvd[W-1]};
        assign diff  = trial - {1'b0, src_dvs};
        assign take  = (trial >= {1'b0, src_dvs});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {src_quo[W-2:0], take};
            end
        end

        if (k < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? diff[W-1:0] : trial[W-1:0];
                    r_dvd[k] <= {src_dvd[W-2:0], 1'b0};
                    r_dvs[k] <= src_dvs;
                end
            end
        end
    end

    assign o_quotient = r_quo[W-1];

endmodule

### rtl/spatial_grid_cell_key_unit.sv
// top level: grid cell key of one point under a linear, morton or hilbert curve
//
//  channel   dir  modport  payload
//  i_cfg     in   sink     index, data      register writes
//  i_pos     in   sink     pos_x, pos_y     one point per transaction
//  o_key     out  source   cell_key         one key per point
//
// one transaction per cycle sustained while o_key is not stalled; a taken point reaches its key through:
// 16 divider stages, one curve prep stage, 15 hilbert level stages, one output register
// i_rst_n is synchronous; it clears the valid bits and loads the register defaults
// a stalled output register freezes every stage at once; nothing is lost or repeated
// register writes are always taken and act at once, so they belong to an empty pipeline
module spatial_grid_cell_key_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sgck_cfg_if.sink     i_cfg,
    sgck_pos_if.sink     i_pos,
    sgck_key_if.source   o_key
);

    localparam int POS_W  = sgck_pkg::POS_W;
    localparam int CRD_W  = sgck_pkg::COORD_BITS;
    localparam int LEN_W  = sgck_pkg::LEN_W;
    localparam int KEY_W  = sgck_pkg::KEY_W;
    localparam int DIV_W  = sgck_pkg::DIV_W;
    localparam int L      = sgck_pkg::HIL_LEVELS;
    localparam int S_W    = sgck_pkg::S_W;
    localparam int SQ_W   = sgck_pkg::SQ_W;
    localparam int PIPE_D = sgck_pkg::PIPE_D;

    // configuration
    logic [LEN_W-1:0]              r_screen_len;
    logic [LEN_W-1:0]              r_cell_size;
    logic [sgck_pkg::MODE_W-1:0]   r_curve_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_len <= sgck_pkg::SCREEN_LENGTH_RST;
            r_cell_size  <= sgck_pkg::CELL_SIZE_RST;
            r_curve_mode <= sgck_pkg::CURVE_HILBERT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                sgck_pkg::REG_SCREEN_LENGTH: r_screen_len <= LEN_W'(i_cfg.data);
                sgck_pkg::REG_CELL_SIZE:     r_cell_size  <= LEN_W'(i_cfg.data);
                sgck_pkg::REG_CURVE_MODE:    r_curve_mode <= sgck_pkg::MODE_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // pipeline control
    logic              r_out_vld;
    logic [KEY_W-1:0]  r_key;
    logic [PIPE_D-1:0] r_vld;
    logic              w_adv;

    assign w_adv       = !r_out_vld || o_key.ready;
    assign i_pos.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[PIPE_D-2:0], i_pos.valid};
            r_out_vld <= r_vld[PIPE_D-1];
        end
    end

    // division
    logic [DIV_W-1:0] w_divisor;
    logic [DIV_W-1:0] w_qx;
    logic [DIV_W-1:0] w_qy;
    logic [DIV_W-1:0] w_qn;

    assign w_divisor = (r_cell_size == '0) ? DIV_W'(1) : DIV_W'(r_cell_size);

    sgck_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (DIV_W'(i_pos.pos_x)),
        .i_divisor  (w_divisor),
        .o_quotient (w_qx)
    );

    sgck_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (DIV_W'(i_pos.pos_y)),
        .i_divisor  (w_divisor),
        .o_quotient (w_qy)
    );

    sgck_div u_div_n (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (DIV_W'(r_screen_len)),
        .i_divisor  (w_divisor),
        .o_quotient (w_qn)
    );

    // curve prep: linear and morton keys, first hilbert square
    logic [CRD_W-1:0] w_cx;
    logic [CRD_W-1:0] w_cy;
    logic [KEY_W-1:0] w_lin;
    logic [KEY_W-1:0] w_mort;
    logic [S_W-1:0]   w_s0;

    logic [POS_W-1:0] r_p_x;
    logic [POS_W-1:0] r_p_y;
    logic [POS_W-1:0] r_p_n;
    logic [SQ_W-1:0]  r_p_sq;
    logic [KEY_W-1:0] r_p_alt;

    assign w_cx   = w_qx[CRD_W-1:0];
    assign w_cy   = w_qy[CRD_W-1:0];
    assign w_lin  = KEY_W'(w_cy) * KEY_W'(w_qn) + KEY_W'(w_cx);
    assign w_mort = KEY_W'(sgck_pkg::spread_bits(w_cx))
                  | (KEY_W'(sgck_pkg::spread_bits(w_cy)) << 1);
    assign w_s0   = w_qn[POS_W-1:1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_x   <= POS_W'(w_cx);
            r_p_y   <= POS_W'(w_cy);
            r_p_n   <= POS_W'(w_qn);
            r_p_sq  <= SQ_W'(w_s0) * SQ_W'(w_s0);
            r_p_alt <= (r_curve_mode == sgck_pkg::CURVE_LINEAR) ? w_lin : w_mort;
        end
    end

    // hilbert levels, step size n >> (k + 1) at level k
    logic [POS_W-1:0] r_h_x   [L];
    logic [POS_W-1:0] r_h_y   [L];
    logic [POS_W-1:0] r_h_n   [L];
    logic [KEY_W-1:0] r_h_d   [L];
    logic [KEY_W-1:0] r_h_alt [L];
    logic [SQ_W-1:0]  r_h_sq  [L-1];

    for (genvar k = 0; k < L; k++) begin : g_lvl
        logic [POS_W-1:0] src_x;
        logic [POS_W-1:0] src_y;
        logic [POS_W-1:0] src_n;
        logic [KEY_W-1:0] src_d;
        logic [KEY_W-1:0] src_alt;
        logic [SQ_W-1:0]  src_sq;
        logic [S_W-1:0]   s;
        logic             rx;
        logic             ry;
        logic [KEY_W-1:0] sq;
        logic [KEY_W-1:0] inc;
        logic [POS_W-1:0] fx;
        logic [POS_W-1:0] fy;

        if (k == 0) begin : g_first
            assign src_x   = r_p_x;
            assign src_y   = r_p_y;
            assign src_n   = r_p_n;
            assign src_d   = '0;
            assign src_alt = r_p_alt;
            assign src_sq  = r_p_sq;
        end else begin : g_next
            assign src_x   = r_h_x[k-1];
            assign src_y   = r_h_y[k-1];
            assign src_n   = r_h_n[k-1];
            assign src_d   = r_h_d[k-1];
            assign src_alt = r_h_alt[k-1];
            assign src_sq  = r_h_sq[k-1];
        end

        assign s  = S_W'(src_n >> (k + 1));
        assign rx = |(src_x & POS_W'(s));
        assign ry = |(src_y & POS_W'(s));
        assign sq = KEY_W'(src_sq);

        always_comb begin
            case ({rx, ry})
                2'b01:   inc = sq;
                2'b11:   inc = sq << 1;
                2'b10:   inc = sq + (sq << 1);
                default: inc = '0;
            endcase
        end

        assign fx = rx ? (src_n - POS_W'(1) - src_x) : src_x;
        assign fy = rx ? (src_n - POS_W'(1) - src_y) : src_y;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_h_x[k]   <= ry ? src_x : fy;
                r_h_y[k]   <= ry ? src_y : fx;
                r_h_n[k]   <= src_n;
                r_h_d[k]   <= src_d + inc;
                r_h_alt[k] <= src_alt;
            end
        end

        if (k < L - 1) begin : g_sq
            logic [S_W-1:0] s_nxt;
            assign s_nxt = S_W'(src_n >> (k + 2));
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_h_sq[k] <= SQ_W'(s_nxt) * SQ_W'(s_nxt);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_key <= (r_curve_mode == sgck_pkg::CURVE_LINEAR ||
                      r_curve_mode == sgck_pkg::CURVE_MORTON) ? r_h_alt[L-1] : r_h_d[L-1];
        end
    end

    assign o_key.valid    = r_out_vld;
    assign o_key.cell_key = r_key;

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pos.valid && i_pos.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_vld[PIPE_D-1]))
        else $error("output became valid without a finished transaction");

    a_small_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_D-1] && r_h_n[L-1] < POS_W'(2)) |-> (r_h_d[L-1] == '0))
        else $error("hilbert key nonzero for a row width below two");

endmodule

### sim/spatial_grid_cell_key_unit_test.sv
// regression bench for the grid cell key unit: directed, backpressure and random point streams
`timescale 1ns / 1ps

module spatial_grid_cell_key_unit_test;

    localparam logic [7:0] RX_PATTERN = 8'b1011_0110;
    localparam int         DRAIN_WAIT = sgck_pkg::PIPE_D + 8;

    logic i_clk;
    logic i_rst_n;

    sgck_cfg_if cfg_ch ();
    sgck_pos_if pos_ch ();
    sgck_key_if key_ch ();

    spatial_grid_cell_key_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pos   (pos_ch),
        .o_key   (key_ch)
    );

    logic [sgck_pkg::LEN_W-1:0]  grid_screen_len;
    logic [sgck_pkg::LEN_W-1:0]  grid_cell_len;
    logic [sgck_pkg::MODE_W-1:0] grid_curve;

    logic [sgck_pkg::KEY_W-1:0] pending_keys[$];
    logic [sgck_pkg::KEY_W-1:0] want_key;
    int               errors;
    int               burst_left;
    bit               sender_gaps;
    int               rx_mode;
    int               rx_tick;
    int               hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("spatial_grid_cell_key_unit regression: fail");
        $finish;
    end

    function automatic logic [sgck_pkg::KEY_W-1:0] hilbert_index(input logic [31:0] hx,
                                                                 input logic [31:0] hy,
                                                                 input logic [31:0] n);
        logic [31:0] s;
        logic [31:0] d;
        logic [31:0] t;
        logic        rx;
        logic        ry;
        d = '0;
        for (s = n >> 1; s != 0; s = s >> 1) begin
            rx = (hx & s) != 0;
            ry = (hy & s) != 0;
            d  = d + (s * s) * 32'({rx, rx ^ ry});
            if (!ry) begin
                if (rx) begin
                    hx = n - 32'd1 - hx;
                    hy = n - 32'd1 - hy;
                end
                t  = hx;
                hx = hy;
                hy = t;
            end
        end
        return d;
    endfunction

    function automatic logic [sgck_pkg::KEY_W-1:0] grid_key(
        input logic [sgck_pkg::POS_W-1:0] px,
        input logic [sgck_pkg::POS_W-1:0] py);
        logic [sgck_pkg::LEN_W-1:0] cs;
        logic [sgck_pkg::LEN_W-1:0] cx;
        logic [sgck_pkg::LEN_W-1:0] cy;
        logic [sgck_pkg::LEN_W-1:0] n;
        logic [sgck_pkg::KEY_W-1:0] k;
        cs = (grid_cell_len == 0) ? sgck_pkg::LEN_W'(1) : grid_cell_len;
        cx = px / cs;
        cy = py / cs;
        n  = grid_screen_len / cs;
        k  = '0;
        case (grid_curve)
            sgck_pkg::CURVE_LINEAR: begin
                k = 32'(cy) * 32'(n) + 32'(cx);
            end
            sgck_pkg::CURVE_MORTON: begin
                for (int i = 0; i < sgck_pkg::COORD_BITS; i++) begin
                    k[2*i]   = cx[i];
                    k[2*i+1] = cy[i];
                end
            end
            default: begin
                k = hilbert_index(32'(cx), 32'(cy), 32'(n));
            end
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) $display("%0t ns: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected key %h", key_ch.cell_key));
            end else begin
                want_key = pending_keys.pop_front();
                if (key_ch.cell_key !== want_key)
                    report_mismatch($sformatf("cell_key %h, wanted %h",
                                              key_ch.cell_key, want_key));
            end
        end
    end

    initial begin
        key_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_left > 0) begin
                key_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    0:       key_ch.ready <= 1'b1;
                    1:       key_ch.ready <= RX_PATTERN[3'(rx_tick)];
                    default: key_ch.ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input sgck_pkg::t_cfg_reg idx,
                             input logic [sgck_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            sgck_pkg::REG_SCREEN_LENGTH: grid_screen_len = value;
            sgck_pkg::REG_CELL_SIZE:     grid_cell_len   = value;
            sgck_pkg::REG_CURVE_MODE:    grid_curve      = value[sgck_pkg::MODE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [sgck_pkg::LEN_W-1:0] screen_len,
                            input logic [sgck_pkg::LEN_W-1:0] cell_len,
                            input logic [sgck_pkg::MODE_W-1:0] curve);
        write_reg(sgck_pkg::REG_SCREEN_LENGTH, screen_len);
        write_reg(sgck_pkg::REG_CELL_SIZE, cell_len);
        write_reg(sgck_pkg::REG_CURVE_MODE, {14'($urandom), curve});
    endtask

    task automatic send_point(input logic [sgck_pkg::POS_W-1:0] px,
                              input logic [sgck_pkg::POS_W-1:0] py);
        int gap;
        @(negedge i_clk);
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= px;
        pos_ch.pos_y <= py;
        do @(posedge i_clk); while (!pos_ch.ready);
        pending_keys.insert(pending_keys.size(), grid_key(px, py));
        if (burst_left > 0) begin
            burst_left--;
        end else if (sender_gaps) begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            pos_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        pos_ch.valid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        rx_mode     = 0;
        sender_gaps = 1'b0;
        send_point(16'd0, 16'd0);
        send_point(16'd4999, 16'd4999);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'd123, 16'd4567);
        wait_drained();
    endtask

    task automatic test_linear();
        rx_mode = 1;
        set_grid(16'd5000, 16'd100, sgck_pkg::CURVE_LINEAR);
        send_point(16'd0, 16'd0);
        send_point(16'd4999, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_morton();
        rx_mode = 2;
        set_grid(16'hFFFF, 16'd1, sgck_pkg::CURVE_MORTON);
        send_point(16'hFFFF, 16'h0000);
        send_point(16'h0000, 16'hFFFF);
        send_point(16'hAAAA, 16'h5555);
        wait_drained();
    endtask

    task automatic test_hilbert();
        rx_mode = 0;
        set_grid(16'hFFFF, 16'd1, sgck_pkg::CURVE_HILBERT);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h8000, 16'h0001);
        send_point(16'h1234, 16'hFEDC);
        wait_drained();
        set_grid(16'd4096, 16'd16, sgck_pkg::CURVE_HILBERT);
        send_point(16'd4095, 16'd0);
        send_point(16'd2048, 16'd2047);
        wait_drained();
    endtask

    task automatic test_special_cases();
        rx_mode = 2;
        // zero cell size acts as one
        set_grid(16'hFFFF, 16'd0, sgck_pkg::CURVE_LINEAR);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'd7, 16'd3);
        wait_drained();
        // unused curve code falls back to hilbert
        set_grid(16'd1000, 16'd10, 2'd3);
        send_point(16'd999, 16'd0);
        send_point(16'd500, 16'd500);
        wait_drained();
        // row width below two
        set_grid(16'd50, 16'd100, sgck_pkg::CURVE_HILBERT);
        send_point(16'hFFFF, 16'd12345);
        wait_drained();
        set_grid(16'd1, 16'hFFFF, sgck_pkg::CURVE_HILBERT);
        send_point(16'hFFFF, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_grid(16'd5000, 16'd100, sgck_pkg::CURVE_MORTON);
        rx_mode     = 0;
        sender_gaps = 1'b0;
        @(posedge i_clk);
        hold_left = 150;
        for (int i = 0; i < 80; i++) send_point(16'($urandom), 16'($urandom));
        wait_drained();
    endtask

    task automatic test_random();
        logic [sgck_pkg::LEN_W-1:0]  sl;
        logic [sgck_pkg::LEN_W-1:0]  cs;
        logic [sgck_pkg::MODE_W-1:0] curve;
        logic [sgck_pkg::POS_W-1:0]  px;
        logic [sgck_pkg::POS_W-1:0]  py;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin sl = 16'hFFFF; cs = 16'd1;    curve = sgck_pkg::CURVE_HILBERT; end
                1: begin sl = 16'hFFFF; cs = 16'd0;    curve = sgck_pkg::CURVE_LINEAR;  end
                2: begin sl = 16'd1;    cs = 16'd1;    curve = sgck_pkg::CURVE_MORTON;  end
                3: begin sl = 16'd8192; cs = 16'd32;   curve = 2'd3;                    end
                4: begin sl = 16'hFFFF; cs = 16'hFFFF; curve = sgck_pkg::CURVE_LINEAR;  end
                default: begin
                    sl    = 16'($urandom_range(1, 65535));
                    cs    = 16'($urandom_range(1, 300));
                    curve = 2'($urandom_range(0, 3));
                end
            endcase
            set_grid(sl, cs, curve);
            rx_mode     = phase % 3;
            sender_gaps = (phase != 2);
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(0, 3) != 0) begin
                    px = 16'($urandom_range(0, int'(sl) - 1));
                    py = 16'($urandom_range(0, int'(sl) - 1));
                end else begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                send_point(px, py);
            end
            wait_drained();
        end
    endtask

    initial begin
        errors          = 0;
        burst_left      = 0;
        sender_gaps     = 1'b0;
        rx_mode         = 0;
        rx_tick         = 0;
        hold_left       = 0;
        grid_screen_len = sgck_pkg::SCREEN_LENGTH_RST;
        grid_cell_len   = sgck_pkg::CELL_SIZE_RST;
        grid_curve      = sgck_pkg::CURVE_HILBERT;
        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = sgck_pkg::REG_SCREEN_LENGTH;
        cfg_ch.data     = '0;
        pos_ch.valid    = 1'b0;
        pos_ch.pos_x    = '0;
        pos_ch.pos_y    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_linear();
        test_morton();
        test_hilbert();
        test_special_cases();
        test_backpressure();
        test_random();

        if (errors == 0) begin
            $display("spatial_grid_cell_key_unit regression: pass");
        end else begin
            $display("spatial_grid_cell_key_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/sgck_pkg.sv
rtl/sgck_if.sv
rtl/sgck_div.sv
rtl/spatial_grid_cell_key_unit.sv
sim/spatial_grid_cell_key_unit_test.sv
